>>> sv/tsia_pkg.sv
`timescale 1ns / 1ps
// Package for the track segment id assigner.
// Holds request/result types, register indexes and reset values; no dependencies.
package tsia_pkg;

  localparam int TRACK_SLOTS_DEF = 4096;
  localparam int TARGET_BITS_DEF = 20;

  localparam int TIME_W   = 24;
  localparam int TRACK_W  = 12;
  localparam int RID_W    = 32;
  localparam int UT_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_END_HASHES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_COAST_HASHES = 2'd2;

  localparam logic [TIME_W-1:0] SEGMENT_TIMEOUT_RST = 24'd76800;

  typedef struct packed {
    logic [TRACK_W-1:0] track_number;
    logic [TIME_W-1:0]  time_of_day;
    logic               begin_flag;
    logic               end_flag;
    logic               coasting_flag;
    logic [RID_W-1:0]   record_id;
  } req_t;

  typedef struct packed {
    logic [UT_W-1:0]  unique_target;
    logic [RID_W-1:0] record_id_out;
    logic             keep_hash;
    logic             opened_segment;
    logic             closed_previous;
    logic             closed_after;
  } res_t;

endpackage

>>> sv/track_segment_id_assigner.sv
`timescale 1ns / 1ps
// Track segment id assigner: per-track segment table and unique target numbering.
// Depends on tsia_pkg for request/result types and register indexes.
//
// Usage:
//   Requests enter on in_req, taken at a clock edge with start high and busy low.
//   Each request yields one result on out_res, marked by out_valid for a single
//   cycle; the receiver cannot stall and must take it.
//   Timing: the table entry is read at the accept edge, modified and written back
//   in the following cycle, and the result is registered at that write edge.
//   out_valid rises at that write edge; busy is high during the update cycle, so a
//   new request is not taken until the previous one has been written back. The
//   single-port table read-modify-write sets this limit.
//   Registers are written on cfg_we/cfg_index/cfg_wdata at any edge; indexes
//   beyond the register list are ignored.
//   Reset: after rst_n is released the table live bits are swept clear, one entry
//   per cycle, over all TRACK_SLOTS entries, with busy high; registers return to their
//   reset values and the target counter to zero.
//   TRACK_SLOTS must be a power of two; track numbers are reduced by it.
module track_segment_id_assigner #(
  parameter int TRACK_SLOTS = tsia_pkg::TRACK_SLOTS_DEF,
  parameter int TARGET_BITS = tsia_pkg::TARGET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  tsia_pkg::req_t                  in_req,
  output logic                            out_valid,
  output tsia_pkg::res_t                  out_res,
  input  logic                            cfg_we,
  input  logic [tsia_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsia_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_BITS = $clog2(TRACK_SLOTS);
  localparam int ENTRY_W   = 1 + TARGET_BITS + tsia_pkg::TIME_W;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TRACK_SLOTS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [SLOT_BITS-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [TARGET_BITS-1:0]      next_target_r, next_target_nxt;
  logic [tsia_pkg::TIME_W-1:0] timeout_r;
  logic                        drop_end_r;
  logic                        drop_coast_r;

  logic [ENTRY_W-1:0]          mem [TRACK_SLOTS];
  logic [ENTRY_W-1:0]          rd_data_r;
  tsia_pkg::req_t              req_r;

  logic                        accept;
  logic [16:0]                 in_trk_ext;
  logic [16:0]                 req_trk_ext;
  logic [SLOT_BITS-1:0]        rd_slot;
  logic [SLOT_BITS-1:0]        req_slot;

  logic                        mem_we;
  logic [SLOT_BITS-1:0]        wr_addr;
  logic [ENTRY_W-1:0]          wr_data;

  logic                        ent_live;
  logic [TARGET_BITS-1:0]      ent_target;
  logic [tsia_pkg::TIME_W-1:0] ent_time;
  logic [tsia_pkg::TIME_W-1:0] gap;
  logic                        closed_prev;
  logic                        opened;
  logic [TARGET_BITS-1:0]      target;
  logic [31:0]                 target_ext;
  logic                        keep;

  logic                        out_valid_nxt;
  tsia_pkg::res_t              out_res_nxt;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign in_trk_ext  = 17'(in_req.track_number);
  assign req_trk_ext = 17'(req_r.track_number);
  assign rd_slot     = in_trk_ext[SLOT_BITS-1:0];
  assign req_slot    = req_trk_ext[SLOT_BITS-1:0];

  assign ent_live   = rd_data_r[ENTRY_W-1];
  assign ent_target = rd_data_r[ENTRY_W-2 -: TARGET_BITS];
  assign ent_time   = rd_data_r[tsia_pkg::TIME_W-1:0];
  assign gap        = req_r.time_of_day - ent_time;

  always_comb begin
    closed_prev = 1'b0;
    if (ent_live) begin
      if (req_r.begin_flag) begin
        closed_prev = 1'b1;
      end else if ((req_r.time_of_day > ent_time) && (gap > timeout_r)) begin
        closed_prev = 1'b1;
      end
    end
    opened     = !ent_live || closed_prev;
    target     = opened ? next_target_r : ent_target;
    target_ext = 32'(target);
    keep       = !((req_r.end_flag && drop_end_r) || (req_r.coasting_flag && drop_coast_r));
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    next_target_nxt = next_target_r;
    mem_we          = 1'b0;
    wr_addr         = req_slot;
    wr_data         = {!req_r.end_flag, target, req_r.time_of_day};
    out_valid_nxt   = 1'b0;
    out_res_nxt     = out_res;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        mem_we        = 1'b1;
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (opened) begin
          next_target_nxt = next_target_r + 1'b1;
        end
        out_res_nxt.unique_target   = target_ext[tsia_pkg::UT_W-1:0];
        out_res_nxt.record_id_out   = req_r.record_id;
        out_res_nxt.keep_hash       = keep;
        out_res_nxt.opened_segment  = opened;
        out_res_nxt.closed_previous = closed_prev;
        out_res_nxt.closed_after    = req_r.end_flag;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      next_target_r <= '0;
      out_valid     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      next_target_r <= next_target_nxt;
      out_valid     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= tsia_pkg::SEGMENT_TIMEOUT_RST;
      drop_end_r   <= 1'b0;
      drop_coast_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsia_pkg::CFG_SEGMENT_TIMEOUT:   timeout_r    <= cfg_wdata[tsia_pkg::TIME_W-1:0];
        tsia_pkg::CFG_DROP_END_HASHES:   drop_end_r   <= cfg_wdata[0];
        tsia_pkg::CFG_DROP_COAST_HASHES: drop_coast_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_nxt;
    if (accept) begin
      req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> busy)
    else $error("request could be accepted during the table clear sweep");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_EXEC))
    else $error("result strobe without a table update cycle");

  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (next_target_r ==
      ($past(next_target_r) + TARGET_BITS'(out_res.opened_segment))))
    else $error("target counter step does not match opened segment");

  a_close_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.closed_previous) |-> out_res.opened_segment)
    else $error("segment closed before update without a new one opened");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted request did not reach the update cycle");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for track_segment_id_assigner: directed and random update requests.
// Depends on tsia_pkg and the track_segment_id_assigner RTL; a class predicts segment numbering.
module testbench;

  localparam logic [tsia_pkg::TIME_W-1:0]    TIME_MAX       = 24'd11059199;
  localparam logic [tsia_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_REQUESTS = 125;

  // flag codes for directed requests: {begin, end, coasting}
  localparam logic [2:0] FL_NONE  = 3'b000;
  localparam logic [2:0] FL_COAST = 3'b001;
  localparam logic [2:0] FL_END   = 3'b010;
  localparam logic [2:0] FL_BEGIN = 3'b100;

  class segment_numbering;
    bit                          live [tsia_pkg::TRACK_SLOTS_DEF];
    logic [tsia_pkg::UT_W-1:0]   owner [tsia_pkg::TRACK_SLOTS_DEF];
    logic [tsia_pkg::TIME_W-1:0] stamp [tsia_pkg::TRACK_SLOTS_DEF];
    logic [tsia_pkg::UT_W-1:0]   next_id = '0;
    logic [tsia_pkg::TIME_W-1:0] timeout = tsia_pkg::SEGMENT_TIMEOUT_RST;
    bit                          drop_end = 1'b0;
    bit                          drop_coast = 1'b0;
    tsia_pkg::res_t              due_results [$];
    int                          failures = 0;

    function void set_register(logic [tsia_pkg::CFG_IDX_W-1:0] idx,
                               logic [tsia_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tsia_pkg::CFG_SEGMENT_TIMEOUT:   timeout = data[tsia_pkg::TIME_W-1:0];
        tsia_pkg::CFG_DROP_END_HASHES:   drop_end = data[0];
        tsia_pkg::CFG_DROP_COAST_HASHES: drop_coast = data[0];
        default: ;
      endcase
    endfunction

    function void take_update(tsia_pkg::req_t r);
      tsia_pkg::res_t e;
      int slot;
      slot = int'(r.track_number) % tsia_pkg::TRACK_SLOTS_DEF;
      e = '0;
      if (live[slot]) begin
        if (r.begin_flag)
          e.closed_previous = 1'b1;
        else if (r.time_of_day > stamp[slot] && (r.time_of_day - stamp[slot]) > timeout)
          e.closed_previous = 1'b1;
        if (e.closed_previous)
          live[slot] = 1'b0;
      end
      if (!live[slot]) begin
        owner[slot] = next_id;
        next_id = next_id + 1'b1;
        live[slot] = 1'b1;
        e.opened_segment = 1'b1;
      end
      e.unique_target = owner[slot];
      stamp[slot] = r.time_of_day;
      e.keep_hash = !((r.end_flag && drop_end) || (r.coasting_flag && drop_coast));
      if (r.end_flag)
        live[slot] = 1'b0;
      e.closed_after = r.end_flag;
      e.record_id_out = r.record_id;
      due_results.push_back(e);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10)
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    function void compare(string name, logic [tsia_pkg::RID_W-1:0] want,
                          logic [tsia_pkg::RID_W-1:0] got);
      if (want !== got)
        report($sformatf("%s: expected %0h, got %0h", name, want, got));
    endfunction

    function void check_result(tsia_pkg::res_t got);
      tsia_pkg::res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %0h with no request outstanding", got));
        return;
      end
      want = due_results.pop_front();
      compare("unique_target", 32'(want.unique_target), 32'(got.unique_target));
      compare("record_id_out", want.record_id_out, got.record_id_out);
      compare("keep_hash", 32'(want.keep_hash), 32'(got.keep_hash));
      compare("opened_segment", 32'(want.opened_segment), 32'(got.opened_segment));
      compare("closed_previous", 32'(want.closed_previous), 32'(got.closed_previous));
      compare("closed_after", 32'(want.closed_after), 32'(got.closed_after));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  tsia_pkg::req_t                  in_req = '0;
  logic                            out_valid;
  tsia_pkg::res_t                  out_res;
  logic                            cfg_we = 1'b0;
  logic [tsia_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tsia_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  segment_numbering sb = new();
  logic [tsia_pkg::TIME_W-1:0] last_sent [tsia_pkg::TRACK_SLOTS_DEF];
  int burst_left = 0;
  int idle_cycles = 0;

  track_segment_id_assigner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0)
        sb.take_update(in_req);
      if (out_valid === 1'b1)
        sb.check_result(out_res);
    end
    if ((start && busy === 1'b0) || out_valid === 1'b1 || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("track_segment_id_assigner verification failed");
      $finish;
    end
  end

  // Holds start high through bursts; drops it for a random gap, possibly none, between bursts.
  task automatic send_item(input tsia_pkg::req_t r);
    int gap;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    last_sent[r.track_number] = r.time_of_day;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 60);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic direct(input logic [tsia_pkg::TRACK_W-1:0] track,
                        input logic [tsia_pkg::TIME_W-1:0] tod,
                        input logic [2:0] flags, input logic [tsia_pkg::RID_W-1:0] rid);
    tsia_pkg::req_t r;
    r.track_number  = track;
    r.time_of_day   = tod;
    r.begin_flag    = flags[2];
    r.end_flag      = flags[1];
    r.coasting_flag = flags[0];
    r.record_id     = rid;
    send_item(r);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tsia_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsia_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // upper data bits of the flag registers are random; only bit 0 counts
  task automatic apply_settings(input logic [tsia_pkg::TIME_W-1:0] timeout,
                                input bit de, input bit dc);
    write_reg(tsia_pkg::CFG_SEGMENT_TIMEOUT, timeout);
    write_reg(tsia_pkg::CFG_DROP_END_HASHES, {23'($urandom_range(0, 8388607)), de});
    write_reg(tsia_pkg::CFG_DROP_COAST_HASHES, {23'($urandom_range(0, 8388607)), dc});
    write_reg(CFG_UNUSED_IDX, 24'($urandom_range(0, 16777215)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [tsia_pkg::TIME_W-1:0] pick_time(
      input logic [tsia_pkg::TRACK_W-1:0] track);
    longint base;
    longint to;
    longint v;
    int mode;
    base = longint'(last_sent[track]);
    to = longint'(sb.timeout);
    mode = $urandom_range(0, 99);
    if (mode < 45)
      v = base + $urandom_range(0, int'(to / 2) + 3);
    else if (mode < 70)
      v = base + to + $urandom_range(0, 2) - 1;
    else if (mode < 80)
      v = base - $urandom_range(1, 1000);
    else
      v = longint'($urandom_range(0, TIME_MAX));
    if (v < 0 || v > TIME_MAX)
      v = longint'($urandom_range(0, TIME_MAX));
    return v[tsia_pkg::TIME_W-1:0];
  endfunction

  // Mostly revisits a small pool of tracks so segments live, time out and end.
  task automatic random_phase(input int count);
    logic [tsia_pkg::TRACK_W-1:0] pool [8];
    tsia_pkg::req_t r;
    int n;
    for (n = 0; n < 8; n++)
      pool[n] = 12'($urandom_range(0, 4095));
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85)
        r.track_number = pool[$urandom_range(0, 7)];
      else
        r.track_number = 12'($urandom_range(0, 4095));
      r.time_of_day   = pick_time(r.track_number);
      r.begin_flag    = ($urandom_range(0, 99) < 15);
      r.end_flag      = ($urandom_range(0, 99) < 15);
      r.coasting_flag = ($urandom_range(0, 99) < 30);
      r.record_id     = $urandom;
      send_item(r);
    end
  endtask

  initial begin
    int p;
    logic [tsia_pkg::TIME_W-1:0] phase_timeout;
    for (p = 0; p < tsia_pkg::TRACK_SLOTS_DEF; p++)
      last_sent[p] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);

    // reset register values
    direct(12'd0, 24'd0, FL_NONE, 32'h0);
    direct(12'd0, 24'd76800, FL_NONE, 32'hFFFF_FFFF);
    direct(12'd0, 24'd153601, FL_NONE, $urandom);
    direct(12'd0, 24'd100, FL_NONE, $urandom);
    direct(12'd4095, TIME_MAX, FL_BEGIN, $urandom);
    direct(12'd4095, TIME_MAX, FL_BEGIN, $urandom);
    direct(12'd4095, TIME_MAX, FL_COAST, $urandom);
    direct(12'd4095, TIME_MAX, FL_END, $urandom);
    direct(12'd4095, 24'd0, FL_NONE, $urandom);
    direct(12'd4095, 24'd1, FL_BEGIN | FL_END, $urandom);
    direct(12'd5, 24'd200, FL_BEGIN | FL_END, $urandom);
    direct(12'd5, 24'd300, FL_BEGIN | FL_END | FL_COAST, $urandom);
    settle();

    apply_settings(24'd0, 1'b1, 1'b1);
    direct(12'd7, 24'd50, FL_NONE, $urandom);
    direct(12'd7, 24'd50, FL_NONE, $urandom);
    direct(12'd7, 24'd51, FL_COAST, $urandom);
    direct(12'd7, 24'd52, FL_END, $urandom);
    direct(12'd7, 24'd60, FL_END | FL_COAST, $urandom);
    direct(12'd9, 24'd10, FL_NONE, $urandom);
    settle();

    apply_settings(TIME_MAX, 1'b0, 1'b1);
    direct(12'd9, TIME_MAX, FL_END, $urandom);
    direct(12'd9, 24'd0, FL_COAST, $urandom);
    settle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: phase_timeout = 24'd0;
        1: phase_timeout = TIME_MAX;
        2: phase_timeout = 24'd1;
        3: phase_timeout = 24'($urandom_range(2, 300));
        4: phase_timeout = 24'($urandom_range(0, TIME_MAX));
        default: phase_timeout = tsia_pkg::SEGMENT_TIMEOUT_RST;
      endcase
      apply_settings(phase_timeout, p[0], p[1]);
      random_phase(PHASE_REQUESTS);
      settle();
    end

    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.due_results.size() == 0)
      $display("track_segment_id_assigner verification clean");
    else
      $display("track_segment_id_assigner verification failed");
    $finish;
  end

endmodule
